// ===== src/wgm_pkg.sv =====
// wgm_pkg: shared types and constants of the wildcard glob matcher
// holds the action codes, the queue entry type and the default sizes
// no dependencies
`default_nettype none

package wgm_pkg;

  localparam int MAX_PATTERN_DEF = 256;
  localparam int CHAR_BITS_DEF   = 16;
  localparam int IN_CHAR_W       = 16;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [IN_CHAR_W-1:0] STAR_CODE  = IN_CHAR_W'(8'h2A);
  localparam logic [IN_CHAR_W-1:0] QUERY_CODE = IN_CHAR_W'(8'h3F);

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_APPEND  = 2'd1,
    OP_SUBJECT = 2'd2,
    OP_END     = 2'd3
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [IN_CHAR_W-1:0] ch;
    logic                 is_star;
    logic                 is_query;
  } entry_t;

endpackage

`default_nettype wire

// ===== src/wgm_front.sv =====
// wgm_front: input side, decodes the action and masks the character
// produces one queue entry per transfer; depends on wgm_pkg
`default_nettype none

module wgm_front import wgm_pkg::*; #(
  parameter int CHAR_BITS = CHAR_BITS_DEF
) (
  input  wire logic [1:0]           in_action,
  input  wire logic [IN_CHAR_W-1:0] in_char_code,
  output entry_t                    entry
);

  localparam int CW = (CHAR_BITS < IN_CHAR_W) ? CHAR_BITS : IN_CHAR_W;
  localparam logic [IN_CHAR_W-1:0] CHAR_MASK =
    (CW >= IN_CHAR_W) ? {IN_CHAR_W{1'b1}} : IN_CHAR_W'((33'd1 << CW) - 33'd1);

  logic [IN_CHAR_W-1:0] ch;

  always_comb begin
    ch             = in_char_code & CHAR_MASK;
    entry.op       = op_t'(in_action);
    entry.ch       = ch;
    entry.is_star  = (ch == STAR_CODE);
    entry.is_query = (ch == QUERY_CODE);
  end

endmodule

`default_nettype wire

// ===== src/wgm_queue.sv =====
// wgm_queue: short fifo between the decode side and the matcher core
// holds classified entries; depends on wgm_pkg
`default_nettype none

module wgm_queue import wgm_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  entry_t      push_entry,
  output logic        full,
  output logic        head_valid,
  output entry_t      head_entry,
  input  wire logic   pop
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t             slot_r [QUEUE_DEPTH];
  logic [PW-1:0]      wr_ptr_r;
  logic [PW-1:0]      rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               do_push;
  logic               do_pop;

  assign full       = (count_r == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

// ===== src/wgm_back.sv =====
// wgm_back: matcher core, pattern cells and active position vector
// executes queue entries and drives the result register; depends on wgm_pkg
`default_nettype none

module wgm_back import wgm_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int CHAR_BITS   = CHAR_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic head_valid,
  input  entry_t    head_entry,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_stall,
  output logic      out_matched,
  output logic      out_overflow
);

  localparam int CW = (CHAR_BITS < IN_CHAR_W) ? CHAR_BITS : IN_CHAR_W;
  localparam int N  = MAX_PATTERN + 1;
  localparam int LW = $clog2(MAX_PATTERN + 1);

  // star runs behave like carry propagation: one wide add closes them
  function automatic logic [N-1:0] star_close(input logic [N-1:0] a, input logic [N-1:0] s);
    logic [N-1:0] g;
    logic [N-1:0] sum;
    g   = a & s;
    sum = s + g;
    return a | (sum ^ s ^ g);
  endfunction

  logic [CW-1:0]          chars_r [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] star_r;
  logic [MAX_PATTERN-1:0] query_r;
  logic [MAX_PATTERN-1:0] filled_r;
  logic [LW-1:0]          len_r;
  logic                   ovf_r;
  logic [N-1:0]           active_r;
  logic                   out_valid_r;
  logic                   out_matched_r;
  logic                   out_overflow_r;

  logic [N-1:0]           star_vec;
  logic [N-1:0]           closed;
  logic [MAX_PATTERN-1:0] adv;
  logic [N-1:0]           step;
  logic [N-1:0]           len_sel;
  logic                   hit;
  logic                   out_free;
  logic [CW-1:0]          sub_ch;

  assign out_valid    = out_valid_r;
  assign out_matched  = out_matched_r;
  assign out_overflow = out_overflow_r;
  assign out_free     = !out_valid_r || !out_stall;
  assign pop          = head_valid && ((head_entry.op != OP_END) || out_free);
  assign sub_ch       = head_entry.ch[CW-1:0];

  always_comb begin
    star_vec = {1'b0, star_r & filled_r};
    closed   = star_close(active_r, star_vec);
    for (int p = 0; p < MAX_PATTERN; p++) begin
      adv[p] = filled_r[p] && !star_r[p] && (query_r[p] || (chars_r[p] == sub_ch));
    end
    for (int p = 0; p < N; p++) begin
      len_sel[p] = (len_r == LW'(p));
    end
    step = (closed & star_vec) | {adv & closed[MAX_PATTERN-1:0], 1'b0};
    hit  = |(closed & len_sel);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r    <= '0;
      len_r       <= '0;
      ovf_r       <= 1'b0;
      active_r    <= N'(1);
      out_valid_r <= 1'b0;
    end else begin
      if (pop && (head_entry.op == OP_END)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (pop) begin
        case (head_entry.op)
          OP_CLEAR: begin
            filled_r <= '0;
            len_r    <= '0;
            ovf_r    <= 1'b0;
            active_r <= N'(1);
          end
          OP_APPEND: begin
            if (len_r < LW'(MAX_PATTERN)) begin
              filled_r <= filled_r | MAX_PATTERN'(len_sel);
              len_r    <= len_r + 1'b1;
            end else begin
              ovf_r <= 1'b1;
            end
            active_r <= N'(1);
          end
          OP_SUBJECT: begin
            active_r <= step;
          end
          OP_END: begin
            active_r <= N'(1);
          end
          default: begin
            active_r <= active_r;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int p = 0; p < MAX_PATTERN; p++) begin
      if (pop && (head_entry.op == OP_APPEND) && len_sel[p]) begin
        chars_r[p] <= sub_ch;
        star_r[p]  <= head_entry.is_star;
        query_r[p] <= head_entry.is_query;
      end
    end
    if (pop && (head_entry.op == OP_END)) begin
      out_matched_r  <= hit && !ovf_r;
      out_overflow_r <= ovf_r;
    end
  end

endmodule

`default_nettype wire

// ===== src/wildcard_glob_matcher.sv =====
// wildcard_glob_matcher: top level, glob match of a subject against a stored pattern
// instantiates wgm_front, wgm_queue and wgm_back; depends on wgm_pkg
//
// Usage:
//   input channel (in_valid / in_stall): in_action selects clear pattern,
//   append pattern char, subject char or end subject; in_char_code carries
//   the character for append and subject char.
//   result channel (out_valid / out_stall): one transfer per end subject,
//   out_matched tells whether the whole subject matched the whole pattern,
//   out_overflow flags a pattern longer than MAX_PATTERN (matched is then 0).
//   '*' matches any run, including an empty one; '?' matches one character.
//   Throughput is one item per cycle while no end subject waits on a stalled
//   result: every pattern position is updated in parallel and star runs are
//   closed by one wide add in the matcher core. An end subject passes through
//   the queue slot and then the result register before out_valid rises.
//   A two-entry queue sits between decode and core; in_stall rises when it
//   is full. While out_stall holds a pending result, non-result items keep
//   flowing, and the next end subject waits in the queue.
//   Reset empties the pattern, clears overflow, restarts the subject and
//   drops any pending result.
`default_nettype none

module wildcard_glob_matcher import wgm_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int CHAR_BITS   = CHAR_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           in_action,
  input  wire logic [IN_CHAR_W-1:0] in_char_code,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_matched,
  output logic                      out_overflow
);

  entry_t in_entry;
  entry_t head_entry;
  logic   q_full;
  logic   head_valid;
  logic   pop;

  assign in_stall = q_full;

  wgm_front #(
    .CHAR_BITS(CHAR_BITS)
  ) u_front (
    .in_action   (in_action),
    .in_char_code(in_char_code),
    .entry       (in_entry)
  );

  wgm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_entry(in_entry),
    .full      (q_full),
    .head_valid(head_valid),
    .head_entry(head_entry),
    .pop       (pop)
  );

  wgm_back #(
    .MAX_PATTERN(MAX_PATTERN),
    .CHAR_BITS  (CHAR_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_valid  (head_valid),
    .head_entry  (head_entry),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_matched (out_matched),
    .out_overflow(out_overflow)
  );

endmodule

`default_nettype wire

// ===== src/wgm_checker.sv =====
// wgm_checker: port-level assertions for wildcard_glob_matcher
// bound to the top level below; depends on nothing else
`default_nettype none

module wgm_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic out_matched,
  input wire logic out_overflow
);

  // no result right after reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result present after reset");

  // overflow forces a miss
  a_ovf_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> !out_matched)
    else $error("match reported with overflow");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_matched) && $stable(out_overflow))
    else $error("stalled result changed");

  // the queue frees a slot once the core drains it
  a_queue_drains: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall && !out_valid |=> !in_stall)
    else $error("queue stuck full with result side free");

endmodule

bind wildcard_glob_matcher wgm_checker u_wgm_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_matched (out_matched),
  .out_overflow(out_overflow)
);

`default_nettype wire

// ===== verif/tb_top.sv =====
// tb_top: self-checking testbench of wildcard_glob_matcher
// loads patterns, streams subjects and checks every end-of-subject verdict
// depends on wgm_pkg and the wildcard_glob_matcher rtl

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wgm_pkg::*;

  localparam logic [IN_CHAR_W-1:0] CH_A = 16'h0061;

  typedef struct {
    logic matched;
    logic overflow;
  } verdict_t;

  class glob_scoreboard;
    logic [IN_CHAR_W-1:0] pat_chars[MAX_PATTERN_DEF];
    int unsigned pat_len;
    bit active[MAX_PATTERN_DEF+1];
    bit ovf_seen;
    verdict_t verdicts[$];
    int errors;

    function new();
      pat_len = 0;
      ovf_seen = 1'b0;
      errors = 0;
      restart();
    endfunction

    function void restart();
      foreach (active[p]) active[p] = 1'b0;
      active[0] = 1'b1;
    endfunction

    // chains through runs of stars in one pass
    function void close_stars();
      for (int p = 0; p < pat_len; p++) begin
        if (active[p] && pat_chars[p] == STAR_CODE) active[p+1] = 1'b1;
      end
    endfunction

    function void step_char(logic [IN_CHAR_W-1:0] ch);
      bit nxt[MAX_PATTERN_DEF+1];
      close_stars();
      foreach (nxt[p]) nxt[p] = 1'b0;
      for (int p = 0; p < pat_len; p++) begin
        if (active[p]) begin
          if (pat_chars[p] == STAR_CODE) nxt[p] = 1'b1;
          else if (pat_chars[p] == QUERY_CODE || pat_chars[p] == ch) nxt[p+1] = 1'b1;
        end
      end
      active = nxt;
    endfunction

    function void note_transfer(op_t op, logic [IN_CHAR_W-1:0] ch);
      verdict_t v;
      case (op)
        OP_CLEAR: begin
          pat_len = 0;
          ovf_seen = 1'b0;
          restart();
        end
        OP_APPEND: begin
          if (pat_len < MAX_PATTERN_DEF) begin
            pat_chars[pat_len] = ch;
            pat_len++;
          end else begin
            ovf_seen = 1'b1;
          end
          restart();
        end
        OP_SUBJECT: step_char(ch);
        default: begin
          close_stars();
          v.matched = active[pat_len] && !ovf_seen;
          v.overflow = ovf_seen;
          verdicts.push_back(v);
          restart();
        end
      endcase
    endfunction

    task report(string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic matched, logic overflow);
      verdict_t v;
      if (verdicts.size() == 0) begin
        report("result transfer with no end of subject pending");
        return;
      end
      v = verdicts.pop_front();
      if (matched !== v.matched)
        report($sformatf("matched %b, expected %b", matched, v.matched));
      if (overflow !== v.overflow)
        report($sformatf("overflow %b, expected %b", overflow, v.overflow));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_action = OP_CLEAR;
  logic [IN_CHAR_W-1:0] in_char_code = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_matched;
  logic                 out_overflow;
  bit                   idle_on = 1'b1;
  int unsigned          n_sent = 0;
  int unsigned          stall_left = 0;
  glob_scoreboard       sb = new();

  wildcard_glob_matcher uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_char_code (in_char_code),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_matched  (out_matched),
    .out_overflow (out_overflow)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_matched, out_overflow);
  end

  task automatic send(op_t op, logic [IN_CHAR_W-1:0] ch);
    if (idle_on && $urandom_range(0, 6) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= op;
    in_char_code <= ch;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_transfer(op, ch);
    n_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.verdicts.size() != 0) @(posedge clk);
  endtask

  function automatic logic [IN_CHAR_W-1:0] pat_char();
    case ($urandom_range(0, 9))
      0, 1: return STAR_CODE;
      2: return QUERY_CODE;
      3: return IN_CHAR_W'($urandom);
      default: return CH_A + IN_CHAR_W'($urandom_range(0, 2));
    endcase
  endfunction

  function automatic logic [IN_CHAR_W-1:0] subj_char();
    if ($urandom_range(0, 7) == 0) return IN_CHAR_W'($urandom);
    return CH_A + IN_CHAR_W'($urandom_range(0, 2));
  endfunction

  // subjects follow the pattern with occasional corruption so both verdicts occur
  task automatic glob_case(int unsigned plen, bit spill);
    logic [IN_CHAR_W-1:0] pq[$];
    logic [IN_CHAR_W-1:0] c;
    int unsigned nsubj;
    send(OP_CLEAR, IN_CHAR_W'($urandom));
    for (int i = 0; i < plen; i++) begin
      c = pat_char();
      pq.push_back(c);
      send(OP_APPEND, c);
    end
    nsubj = (plen > 16) ? 1 : $urandom_range(1, 4);
    repeat (nsubj) begin
      foreach (pq[i]) begin
        if (pq[i] == STAR_CODE) begin
          repeat ($urandom_range(0, 2)) send(OP_SUBJECT, subj_char());
        end else if ($urandom_range(0, 11) == 0) begin
          if ($urandom_range(0, 1) == 0) send(OP_SUBJECT, subj_char());
        end else if (pq[i] == QUERY_CODE) begin
          send(OP_SUBJECT, subj_char());
        end else begin
          send(OP_SUBJECT, pq[i]);
        end
      end
      if ($urandom_range(0, 9) == 0) send(OP_SUBJECT, subj_char());
      send(OP_END, IN_CHAR_W'($urandom));
    end
    if (spill) begin
      repeat ($urandom_range(1, 3)) send(OP_APPEND, pat_char());
      repeat ($urandom_range(0, 3)) send(OP_SUBJECT, subj_char());
      send(OP_END, IN_CHAR_W'($urandom));
      send(OP_END, IN_CHAR_W'($urandom));
    end
  endtask

  initial begin
    int unsigned scen;
    scen = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(OP_END, 16'h0000);
    send(OP_SUBJECT, 16'hFFFF);
    send(OP_END, 16'hFFFF);
    send(OP_APPEND, STAR_CODE);
    send(OP_APPEND, STAR_CODE);
    send(OP_END, 16'h0000);
    send(OP_SUBJECT, 16'h0000);
    send(OP_SUBJECT, 16'hFFFF);
    send(OP_END, 16'h0000);
    send(OP_CLEAR, 16'hFFFF);
    send(OP_APPEND, 16'hFFFF);
    send(OP_APPEND, QUERY_CODE);
    send(OP_APPEND, 16'h012A);
    send(OP_SUBJECT, 16'hFFFF);
    send(OP_SUBJECT, 16'h0000);
    send(OP_SUBJECT, 16'h012A);
    send(OP_END, 16'h0000);
    send(OP_SUBJECT, 16'hFFFF);
    send(OP_END, 16'h0000);
    send(OP_SUBJECT, 16'hFFFF);
    send(OP_APPEND, STAR_CODE);
    send(OP_END, 16'h0000);
    send(OP_SUBJECT, 16'h0000);
    send(OP_CLEAR, 16'h0000);
    send(OP_END, 16'hFFFF);

    while (n_sent < 1150) begin
      if (scen == 12) begin
        glob_case(MAX_PATTERN_DEF, 1'b1);
      end else if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 6)) send(op_t'($urandom_range(0, 3)), IN_CHAR_W'($urandom));
      end else begin
        glob_case($urandom_range(0, 8), 1'b0);
      end
      if (scen == 30) drain();
      if (n_sent > 1000) idle_on <= 1'b0;
      scen++;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== wildcard_glob_matcher.f =====
src/wgm_pkg.sv
src/wgm_front.sv
src/wgm_queue.sv
src/wgm_back.sv
src/wildcard_glob_matcher.sv
src/wgm_checker.sv
verif/tb_top.sv
